### rtl/core/arpc_pkg.sv
// shared types, codes and constants of the arp cache and responder
package arpc_pkg;

  localparam int unsigned TABLE_ENTRIES_DEF = 32;
  localparam int unsigned SLOT_W = 5;
  localparam int unsigned MAC_W = 48;
  localparam int unsigned IP_W = 32;

  localparam logic [15:0] HW_ETHERNET = 16'h0001;
  localparam logic [15:0] PROTO_IPV4 = 16'h0800;
  localparam logic [15:0] OP_REQUEST = 16'h0001;

  typedef enum logic [1:0] {
    STS_OK        = 2'd0,
    STS_BAD_HW    = 2'd1,
    STS_BAD_PROTO = 2'd2
  } arpc_status_e;

  typedef struct packed {
    logic [15:0]      hw_type;
    logic [15:0]      proto_type;
    logic [15:0]      arp_op;
    logic [7:0]       hw_len;
    logic [7:0]       proto_len;
    logic [MAC_W-1:0] sender_mac;
    logic [IP_W-1:0]  sender_ip;
    logic [IP_W-1:0]  target_ip;
  } arpc_in_t;

  typedef struct packed {
    logic [1:0]        status;
    logic              was_update;
    logic [SLOT_W-1:0] slot;
    logic              reply_valid;
    logic [MAC_W-1:0]  reply_dest_mac;
    logic [IP_W-1:0]   reply_dest_ip;
    logic [IP_W-1:0]   reply_src_ip;
    logic [7:0]        reply_hw_len;
    logic [7:0]        reply_proto_len;
  } arpc_out_t;

  typedef struct packed {
    logic load;
    logic scan_start;
    logic scan_step;
    logic commit;
    logic out_rej;
  } arpc_cmd_t;

  typedef struct packed {
    logic rejected;
    logic scan_done;
    logic out_free;
  } arpc_sts_t;

endpackage

### rtl/core/arpc_in_if.sv
// handshake channel carrying one decoded arp packet
interface arpc_in_if import arpc_pkg::*; ();
  logic     valid;
  logic     ready;
  arpc_in_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### rtl/core/arpc_out_if.sv
// handshake channel carrying one cache result item
interface arpc_out_if import arpc_pkg::*; ();
  logic      valid;
  logic      ready;
  arpc_out_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### rtl/core/arpc_ctrl.sv
// controller state machine sequencing check, scan and commit
module arpc_ctrl import arpc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  arpc_sts_t sts_i,
  output arpc_cmd_t cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SCAN,
    ST_COMMIT
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (sts_i.rejected) begin
          if (sts_i.out_free) begin
            cmd_o.out_rej = 1'b1;
            state_d = ST_IDLE;
          end
        end else begin
          cmd_o.scan_start = 1'b1;
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (sts_i.scan_done) begin
          state_d = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        if (sts_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### rtl/core/arpc_dp.sv
// datapath: item register, cache store, serial lookup, replacement and result register
module arpc_dp import arpc_pkg::*; #(
  parameter int unsigned TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [MAC_W-1:0] cfg_wdata_i,
  input  arpc_in_t         in_data_i,
  input  arpc_cmd_t        cmd_i,
  output arpc_sts_t        sts_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output arpc_out_t        out_data_o
);

  localparam int unsigned IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned CW = $clog2(TABLE_ENTRIES + 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(TABLE_ENTRIES);
  localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_ENTRIES - 1);

  logic [IP_W-1:0]  ip_mem [TABLE_ENTRIES];
  logic [MAC_W-1:0] mac_mem [TABLE_ENTRIES];

  arpc_in_t         item_q;
  arpc_out_t        out_q, out_d;
  logic             out_vld_q;
  logic [MAC_W-1:0] own_mac_q;
  logic [CW-1:0]    fill_q;
  logic [IW-1:0]    rp_q;
  logic [CW-1:0]    scan_q;
  logic             cmp_vld_q;
  logic [IW-1:0]    cmp_idx_q;
  logic [IP_W-1:0]  rd_ip_q;
  logic             hit_q;
  logic [IW-1:0]    hit_idx_q;

  logic             scan_lt;
  logic             hit_now;
  logic             fill_lt;
  logic [IW-1:0]    wr_pos;
  arpc_status_e     rej_code;
  logic             out_free;

  assign scan_lt = scan_q < fill_q;
  assign hit_now = cmp_vld_q && (rd_ip_q == item_q.sender_ip);
  assign fill_lt = fill_q < FULL_CNT;
  assign wr_pos  = hit_q ? hit_idx_q : (fill_lt ? fill_q[IW-1:0] : rp_q);
  assign out_free = !out_vld_q || out_ready_i;

  always_comb begin
    if (item_q.hw_type != HW_ETHERNET) begin
      rej_code = STS_BAD_HW;
    end else if (item_q.proto_type != PROTO_IPV4) begin
      rej_code = STS_BAD_PROTO;
    end else begin
      rej_code = STS_OK;
    end
  end

  assign sts_o.rejected  = (rej_code != STS_OK);
  assign sts_o.scan_done = hit_now || (!cmp_vld_q && !scan_lt);
  assign sts_o.out_free  = out_free;

  always_comb begin
    out_d = '0;
    if (cmd_i.out_rej) begin
      out_d.status = rej_code;
    end else begin
      out_d.status = STS_OK;
      out_d.was_update = hit_q;
      out_d.slot = SLOT_W'(wr_pos);
      if (item_q.arp_op == OP_REQUEST) begin
        out_d.reply_valid = 1'b1;
        out_d.reply_dest_mac = item_q.sender_mac;
        out_d.reply_dest_ip = item_q.sender_ip;
        out_d.reply_src_ip = item_q.target_ip;
        out_d.reply_hw_len = item_q.hw_len;
        out_d.reply_proto_len = item_q.proto_len;
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_mac_q <= '0;
      fill_q <= '0;
      rp_q <= '0;
      scan_q <= '0;
      cmp_vld_q <= 1'b0;
      hit_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        own_mac_q <= cfg_wdata_i;
      end
      if (cmd_i.scan_start) begin
        scan_q <= '0;
        cmp_vld_q <= 1'b0;
        hit_q <= 1'b0;
      end else if (cmd_i.scan_step) begin
        cmp_vld_q <= scan_lt;
        if (scan_lt) begin
          scan_q <= scan_q + CW'(1);
        end
        if (hit_now) begin
          hit_q <= 1'b1;
        end
      end
      if (cmd_i.commit && !hit_q) begin
        if (fill_lt) begin
          fill_q <= fill_q + CW'(1);
        end else begin
          rp_q <= (rp_q == LAST_IDX) ? '0 : rp_q + IW'(1);
        end
      end
      if (cmd_i.commit || cmd_i.out_rej) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // payload and cache store
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q <= in_data_i;
    end
    if (cmd_i.scan_step && scan_lt) begin
      rd_ip_q <= ip_mem[scan_q[IW-1:0]];
      cmp_idx_q <= scan_q[IW-1:0];
    end
    if (cmd_i.scan_step && hit_now) begin
      hit_idx_q <= cmp_idx_q;
    end
    if (cmd_i.commit) begin
      mac_mem[wr_pos] <= item_q.sender_mac;
      if (!hit_q) begin
        ip_mem[wr_pos] <= item_q.sender_ip;
      end
    end
    if (cmd_i.commit || cmd_i.out_rej) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o = out_q;

endmodule

### rtl/core/arp_cache_and_responder.sv
// arp cache and responder top level
//
// in_if takes the decoded fields of one received arp packet per item; out_if
// gives one result item per packet: status, whether the entry was refreshed,
// the slot written and, for a request, the reply fields. cfg_we_i writes the
// station mac from cfg_wdata_i; the user is bound to write it only while the
// block is idle, which the block itself does not enforce. packets with a
// hardware type other than ethernet or a protocol other than ipv4 pass the
// check state and give their result once the result register is free,
// leaving the cache untouched. other packets scan the filled part of the cache
// one entry per cycle through a registered read of the address store, stopping
// at a hit, then commit one write once the result register is free.
// one item is worked on at a time; in_if.ready is high only between items.
// the result register holds a finished item while out_if stalls, and the
// next item is accepted and checked or scanned meanwhile, waiting for the register.
// reset empties the cache at once (a fill count marks the used slots),
// zeroes the replace pointer and the station mac, and drops any result.
module arp_cache_and_responder import arpc_pkg::*; #(
  parameter int unsigned TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [MAC_W-1:0] cfg_wdata_i,
  arpc_in_if.sink          in_if,
  arpc_out_if.source       out_if
);

  arpc_cmd_t cmd;
  arpc_sts_t sts;

  arpc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_if.valid),
    .in_ready_o (in_if.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  arpc_dp #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (in_if.data),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_if.valid),
    .out_ready_i (out_if.ready),
    .out_data_o  (out_if.data)
  );

endmodule

### rtl/core/arpc_chk.sv
// port-level checks of the arp cache and responder
module arpc_chk import arpc_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_i,
  input logic      out_valid_i,
  input logic      out_ready_i,
  input arpc_out_t out_data_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result item dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_data_i))
    else $error("result item changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("item accepted while previous one still in work");

  a_reject_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_data_i.status != STS_OK) |->
      !out_data_i.was_update && !out_data_i.reply_valid && (out_data_i.slot == '0))
    else $error("rejected item carries cache or reply fields");

  a_reply_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_data_i.reply_valid |->
      (out_data_i.reply_dest_mac == '0) && (out_data_i.reply_src_ip == '0))
    else $error("reply fields set without a reply");

endmodule

bind arp_cache_and_responder arpc_chk u_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_if.valid),
  .in_ready_i  (in_if.ready),
  .out_valid_i (out_if.valid),
  .out_ready_i (out_if.ready),
  .out_data_i  (out_if.data)
);
